### rtl/nbgs_pkg.sv
// ----------------------------------------------------------------------------
// nbgs_pkg: shared types and constants of the 2D gravity particle store
// Request and response layouts, command and status codes, fixed-point widths
// and the saturation and magnitude helpers used by the datapath.
// ----------------------------------------------------------------------------
package nbgs_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int FRACTION_BITS = 24;

   localparam int SLOT_W    = 10;
   localparam int COUNT_W   = 11;
   localparam int ADDR_W    = SLOT_W + 1;
   localparam int RAM_DEPTH = 2 * MAX_PARTICLES;
   localparam int VAL_W     = 48;
   localparam int PAIR_W    = 2 * VAL_W;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;

   // difference of two values, magnitude reduced to Q16
   localparam int DIFF_W    = VAL_W + 2;
   localparam int RED_SHIFT = FRACTION_BITS - 16;
   localparam int MAG_W     = DIFF_W - RED_SHIFT;
   localparam int SMALL_W   = 31;

   localparam int DIV_W       = 64;
   localparam int ROOT_W      = DIV_W / 2;
   localparam int MUL_X_W     = 33;
   localparam int MUL_Y_W     = 31;
   localparam int PROD_W      = MUL_X_W + MUL_Y_W;
   localparam int ACC_W       = 64;
   localparam int TERM_W      = FRACTION_BITS + 1;
   localparam int SCALE_SHIFT = 32;
   localparam int CEN_SHIFT   = 32 - FRACTION_BITS;
   localparam int PAIR_SHIFT  = 63 - FRACTION_BITS;

   // divide by ten after the final shift: floor(floor(p / 2^k) / 10) is the
   // same as floor(floor(p / 10) / 2^k), and the shifted value fits 32 bits
   localparam int TEN_IN_W    = PROD_W - PAIR_SHIFT;
   localparam int TEN_RECIP_W = 32;
   localparam int TEN_PROD_W  = TEN_IN_W + TEN_RECIP_W;
   localparam int TEN_SHIFT   = 35;
   localparam logic [TEN_RECIP_W-1:0] TEN_RECIP = 32'hCCCC_CCCD;

   localparam logic [DIV_W-1:0] FIVE_D2    = DIV_W'(5) << SCALE_SHIFT;
   localparam logic [DIV_W-1:0] RECIP_NUM  = DIV_W'(1) << (DIV_W - 1);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_STEP = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_UNUSED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_RADIUS = 2'd2;

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [VAL_W-1:0] new_pos_x;
      logic signed [VAL_W-1:0] new_pos_y;
      logic signed [VAL_W-1:0] new_vel_x;
      logic signed [VAL_W-1:0] new_vel_y;
      logic [SLOT_W-1:0]       read_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [SLOT_W-1:0]       slot;
      logic [COUNT_W-1:0]      count;
      logic signed [VAL_W-1:0] out_pos_x;
      logic signed [VAL_W-1:0] out_pos_y;
      logic signed [VAL_W-1:0] out_vel_x;
      logic signed [VAL_W-1:0] out_vel_y;
   } rsp_type;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W:0] v);
      logic signed [VAL_W-1:0] res;
      if (v > (ACC_W+1)'(VAL_MAX)) begin
         res = VAL_MAX;
      end else if (v < (ACC_W+1)'(VAL_MIN)) begin
         res = VAL_MIN;
      end else begin
         res = VAL_W'(v);
      end
      return res;
   endfunction

   // magnitude truncated to Q16
   function automatic logic [MAG_W-1:0] reduce_mag(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] m;
      m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
      return m[DIFF_W-1:RED_SHIFT];
   endfunction

endpackage

### rtl/nbody_gravity_step_2d_top.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step_2d_top: 2D gravity particle store
// Add, step and read commands on a double-banked particle store held in two
// RAMs (positions, velocities), with an all-pairs force sequencer.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   req_     | in        | req_valid/req_stall | req_data (req_type)
//   rsp_     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//   csr_     | in        | csr_write           | csr_index, csr_data
//
// Sequence: an add or unknown command passes the done state into the response
// register; a read also passes the read state. A step works through all pairs;
// each pair costs one square root and three divisions on the single shared
// divider, and the divide by ten is a reciprocal multiply. Pairs too far apart
// to contribute skip the square root and the divisions.
// Reset: synchronous; clears the state, count and bank select, loads CSR defaults.
// The RAMs are not cleared: only entries below the count are ever read.
// Stalls: one request is worked on at a time. A finished response waits in
// the output register while the next request is already taken; the block
// then holds that result until the output frees up.
// ----------------------------------------------------------------------------
module nbody_gravity_step_2d_top
   import nbgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_READ   = 20'h00002,
      S_LOAD_I = 20'h00004,
      S_GET_I  = 20'h00008,
      S_SHIFT  = 20'h00010,
      S_SQ_A   = 20'h00020,
      S_SQ_B   = 20'h00040,
      S_SUM    = 20'h00080,
      S_ROOT   = 20'h00100,
      S_RECIP  = 20'h00200,
      S_DIV    = 20'h00400,
      S_MUL    = 20'h00800,
      S_TEN    = 20'h01000,
      S_ACC    = 20'h02000,
      S_NEXT_J = 20'h04000,
      S_LOAD_J = 20'h08000,
      S_GET_J  = 20'h10000,
      S_VEL    = 20'h20000,
      S_POS    = 20'h40000,
      S_DONE   = 20'h80000
   } state_type;

   // working registers of the step sequencer
   typedef struct packed {
      logic [COUNT_W-1:0]      i;
      logic [COUNT_W-1:0]      j;
      logic signed [VAL_W-1:0] px;
      logic signed [VAL_W-1:0] py;
      logic signed [VAL_W-1:0] vx;
      logic signed [VAL_W-1:0] vy;
      logic signed [ACC_W-1:0] fx;
      logic signed [ACC_W-1:0] fy;
      logic [MAG_W-1:0]        a;
      logic [MAG_W-1:0]        b;
      logic                    sa;
      logic                    sb;
      logic                    inner;
      logic                    central;
      logic                    axis;
      logic [PROD_W-1:0]       sq;
      logic [PROD_W-1:0]       prod;
      logic [DIV_W-1:0]        d2;
      logic [ROOT_W-1:0]       d;
      logic [MUL_Y_W-1:0]      r;
      logic [MUL_X_W-1:0]      t;
      logic [TERM_W-1:0]       term;
   } work_type;

   state_type          state_ff, state_in;
   work_type           work_ff, work_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               go_ff, go_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               bank_ff, bank_in;
   logic [CFG_W-1:0]   cx_ff, cx_in;
   logic [CFG_W-1:0]   cy_ff, cy_in;
   logic [CFG_W-1:0]   rad_ff, rad_in;

   // memory ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [PAIR_W-1:0] pos_wdata, vel_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [PAIR_W-1:0] pos_rdata, vel_rdata;

   // arithmetic units
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_num, div_den, div_quo;
   logic              sqrt_start, sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;
   logic [MUL_X_W-1:0] mul_x;
   logic [MUL_Y_W-1:0] mul_y;
   logic [PROD_W-1:0]  mul_p;
   logic [TEN_PROD_W-1:0] ten_prod;

   // datapath helpers
   logic                    accept;
   logic signed [VAL_W-1:0] rd_px, rd_py;
   logic signed [DIFF_W-1:0] cen_x, cen_y, diff_x, diff_y;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic                    big_x, big_y;
   logic [SMALL_W-1:0]      sel_mag;
   logic [PROD_W-1:0]       sum_sq;
   logic [2*CFG_W-1:0]      rad_sq;
   logic [PROD_W-1:0]       quiet_lim;
   logic signed [ACC_W-1:0] term_val;
   logic                    term_neg;
   logic                    unit_done;
   logic signed [VAL_W-1:0] npx, npy;
   logic [COUNT_W-1:0]      i_next, j_next;
   logic                    full;

   nbgs_ram #(.WIDTH(PAIR_W), .DEPTH(RAM_DEPTH)) u_pos_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (pos_wdata),
      .rd_addr (ram_raddr),
      .rd_data (pos_rdata)
   );

   nbgs_ram #(.WIDTH(PAIR_W), .DEPTH(RAM_DEPTH)) u_vel_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (vel_wdata),
      .rd_addr (ram_raddr),
      .rd_data (vel_rdata)
   );

   nbgs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   nbgs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (work_ff.d2),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // only idle takes a request
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign full      = (count_ff == COUNT_W'(MAX_PARTICLES));
   assign i_next    = work_ff.i + 1'b1;
   assign j_next    = work_ff.j + 1'b1;

   // read address: particle i, particle j, or the slot of a read request
   always_comb begin
      if (state_ff == S_LOAD_I) begin
         ram_raddr = {bank_ff, work_ff.i[SLOT_W-1:0]};
      end else if (state_ff == S_LOAD_J) begin
         ram_raddr = {bank_ff, work_ff.j[SLOT_W-1:0]};
      end else begin
         ram_raddr = {bank_ff, req_data.read_slot};
      end
   end

   // differences toward the centre (particle i) or toward particle j
   assign rd_px  = $signed(pos_rdata[PAIR_W-1:VAL_W]);
   assign rd_py  = $signed(pos_rdata[VAL_W-1:0]);
   assign cen_x  = $signed(DIFF_W'(cx_ff) << FRACTION_BITS);
   assign cen_y  = $signed(DIFF_W'(cy_ff) << FRACTION_BITS);
   assign diff_x = (state_ff == S_GET_I) ? cen_x - DIFF_W'(rd_px)
                                         : DIFF_W'(rd_px) - DIFF_W'(work_ff.px);
   assign diff_y = (state_ff == S_GET_I) ? cen_y - DIFF_W'(rd_py)
                                         : DIFF_W'(rd_py) - DIFF_W'(work_ff.py);
   assign mag_x  = reduce_mag(diff_x);
   assign mag_y  = reduce_mag(diff_y);
   assign big_x  = |mag_x[MAG_W-1:SMALL_W];
   assign big_y  = |mag_y[MAG_W-1:SMALL_W];

   // shared multiplier: squares, then t * r
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      if (state_ff == S_SQ_A) begin
         mul_x = MUL_X_W'(work_ff.a[SMALL_W-1:0]);
         mul_y = work_ff.a[SMALL_W-1:0];
      end else if (state_ff == S_SQ_B) begin
         mul_x = MUL_X_W'(work_ff.b[SMALL_W-1:0]);
         mul_y = work_ff.b[SMALL_W-1:0];
      end else if (state_ff == S_MUL) begin
         mul_x = work_ff.t;
         mul_y = work_ff.r;
      end
   end
   assign mul_p = mul_x * mul_y;

   // shift the pair product down first, then divide by ten by reciprocal
   assign ten_prod = TEN_PROD_W'(work_ff.prod[PROD_W-1:PAIR_SHIFT]) * TEN_PROD_W'(TEN_RECIP);

   assign sum_sq    = work_ff.sq + work_ff.prod;
   assign rad_sq    = rad_ff * rad_ff;
   assign quiet_lim = PROD_W'(rad_sq) << SCALE_SHIFT;

   // divider operands: reciprocal, direction cosine
   assign sel_mag = work_ff.axis ? work_ff.b[SMALL_W-1:0] : work_ff.a[SMALL_W-1:0];
   always_comb begin
      div_num = RECIP_NUM;
      div_den = work_ff.d2;
      if (state_ff == S_DIV) begin
         div_num = DIV_W'(sel_mag) << SCALE_SHIFT;
         div_den = DIV_W'(work_ff.d);
      end
   end
   assign div_start  = !go_ff && ((state_ff == S_RECIP) || (state_ff == S_DIV));
   assign sqrt_start = !go_ff && (state_ff == S_ROOT);
   assign unit_done  = (state_ff == S_ROOT) ? sqrt_done : div_done;

   assign term_neg = work_ff.axis ? work_ff.sb : work_ff.sa;
   assign term_val = $signed(ACC_W'(work_ff.term));

   assign npx = sat_val((ACC_W+1)'(work_ff.px) + (ACC_W+1)'(work_ff.vx));
   assign npy = sat_val((ACC_W+1)'(work_ff.py) + (ACC_W+1)'(work_ff.vy));

   // memory writes: add fills the current bank, a step writes the other one
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {bank_ff, count_ff[SLOT_W-1:0]};
      pos_wdata = {req_data.new_pos_x, req_data.new_pos_y};
      vel_wdata = {req_data.new_vel_x, req_data.new_vel_y};
      if (state_ff == S_POS) begin
         ram_we    = 1'b1;
         ram_waddr = {!bank_ff, work_ff.i[SLOT_W-1:0]};
         pos_wdata = {npx, npy};
         vel_wdata = {work_ff.vx, work_ff.vy};
      end else if (accept && (req_data.cmd == CMD_ADD) && !full) begin
         ram_we = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      res_in       = res_ff;
      go_in        = go_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            go_in = 1'b0;
            if (accept) begin
               res_in       = '0;
               res_in.count = count_ff;
               state_in     = S_DONE;
               case (req_data.cmd)
                  CMD_ADD: begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        res_in.slot  = count_ff[SLOT_W-1:0];
                        res_in.count = count_ff + 1'b1;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  CMD_STEP: begin
                     if (count_ff == '0) begin
                        bank_in = !bank_ff;
                     end else begin
                        work_in.i = '0;
                        state_in  = S_LOAD_I;
                     end
                  end
                  CMD_READ: begin
                     res_in.slot = req_data.read_slot;
                     if (COUNT_W'(req_data.read_slot) >= count_ff) begin
                        res_in.status = STATUS_UNUSED;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            res_in.out_pos_x = rd_px;
            res_in.out_pos_y = rd_py;
            res_in.out_vel_x = $signed(vel_rdata[PAIR_W-1:VAL_W]);
            res_in.out_vel_y = $signed(vel_rdata[VAL_W-1:0]);
            state_in         = S_DONE;
         end

         S_LOAD_I: begin
            state_in = S_GET_I;
         end

         S_GET_I: begin
            work_in.px      = rd_px;
            work_in.py      = rd_py;
            work_in.vx      = $signed(vel_rdata[PAIR_W-1:VAL_W]);
            work_in.vy      = $signed(vel_rdata[VAL_W-1:0]);
            work_in.fx      = '0;
            work_in.fy      = '0;
            work_in.a       = mag_x;
            work_in.b       = mag_y;
            work_in.sa      = diff_x[DIFF_W-1];
            work_in.sb      = diff_y[DIFF_W-1];
            work_in.inner   = !big_x && !big_y;
            work_in.central = 1'b1;
            state_in        = S_SHIFT;
         end

         S_SHIFT: begin
            // scale both down together until they fit the squarer
            if ((|work_ff.a[MAG_W-1:SMALL_W]) || (|work_ff.b[MAG_W-1:SMALL_W])) begin
               work_in.a = work_ff.a >> 1;
               work_in.b = work_ff.b >> 1;
            end else begin
               state_in = S_SQ_A;
            end
         end

         S_SQ_A: begin
            work_in.prod = mul_p;
            state_in     = S_SQ_B;
         end

         S_SQ_B: begin
            work_in.sq   = work_ff.prod;
            work_in.prod = mul_p;
            state_in     = S_SUM;
         end

         S_SUM: begin
            if (work_ff.central) begin
               if (work_ff.inner && (sum_sq <= quiet_lim)) begin
                  // inside the quiet radius: no central pull
                  work_in.central = 1'b0;
                  work_in.j       = '0;
                  state_in        = S_LOAD_J;
               end else begin
                  work_in.d2 = sum_sq;
                  state_in   = S_ROOT;
               end
            end else begin
               work_in.d2 = (sum_sq < FIVE_D2) ? FIVE_D2 : sum_sq;
               state_in   = S_ROOT;
            end
         end

         S_ROOT: begin
            if (!go_ff) begin
               go_in = 1'b1;
            end else if (unit_done) begin
               go_in        = 1'b0;
               work_in.d    = sqrt_root;
               work_in.axis = 1'b0;
               if (!work_ff.central) begin
                  state_in = S_RECIP;
               end else if (sqrt_root == '0) begin
                  work_in.central = 1'b0;
                  work_in.j       = '0;
                  state_in        = S_LOAD_J;
               end else begin
                  state_in = S_DIV;
               end
            end
         end

         S_RECIP: begin
            if (!go_ff) begin
               go_in = 1'b1;
            end else if (unit_done) begin
               go_in     = 1'b0;
               work_in.r = div_quo[MUL_Y_W-1:0];
               state_in  = S_DIV;
            end
         end

         S_DIV: begin
            if (!go_ff) begin
               go_in = 1'b1;
            end else if (unit_done) begin
               go_in = 1'b0;
               if (work_ff.central) begin
                  work_in.term = TERM_W'(div_quo >> CEN_SHIFT);
                  state_in     = S_ACC;
               end else begin
                  work_in.t = div_quo[MUL_X_W-1:0];
                  state_in  = S_MUL;
               end
            end
         end

         S_MUL: begin
            work_in.prod = mul_p;
            state_in     = S_TEN;
         end

         S_TEN: begin
            work_in.term = TERM_W'(ten_prod >> TEN_SHIFT);
            state_in     = S_ACC;
         end

         S_ACC: begin
            if (!work_ff.axis) begin
               work_in.fx   = term_neg ? work_ff.fx - term_val : work_ff.fx + term_val;
               work_in.axis = 1'b1;
               state_in     = S_DIV;
            end else begin
               work_in.fy = term_neg ? work_ff.fy - term_val : work_ff.fy + term_val;
               if (work_ff.central) begin
                  work_in.central = 1'b0;
                  work_in.j       = '0;
                  state_in        = S_LOAD_J;
               end else begin
                  state_in = S_NEXT_J;
               end
            end
         end

         S_NEXT_J: begin
            if (j_next < count_ff) begin
               work_in.j = j_next;
               state_in  = S_LOAD_J;
            end else begin
               state_in = S_VEL;
            end
         end

         S_LOAD_J: begin
            state_in = S_GET_J;
         end

         S_GET_J: begin
            // drop pairs too far apart to give a single LSB
            if (big_x || big_y) begin
               state_in = S_NEXT_J;
            end else begin
               work_in.a  = mag_x;
               work_in.b  = mag_y;
               work_in.sa = diff_x[DIFF_W-1];
               work_in.sb = diff_y[DIFF_W-1];
               state_in   = S_SQ_A;
            end
         end

         S_VEL: begin
            work_in.vx = sat_val((ACC_W+1)'(work_ff.vx) + (ACC_W+1)'(work_ff.fx));
            work_in.vy = sat_val((ACC_W+1)'(work_ff.vy) + (ACC_W+1)'(work_ff.fy));
            state_in   = S_POS;
         end

         S_POS: begin
            if (i_next < count_ff) begin
               work_in.i = i_next;
               state_in  = S_LOAD_I;
            end else begin
               bank_in      = !bank_ff;
               res_in       = '0;
               res_in.count = count_ff;
               state_in     = S_DONE;
            end
         end

         S_DONE: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      rad_in = rad_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CENTER_X:     cx_in  = csr_data;
            CSR_CENTER_Y:     cy_in  = csr_data;
            CSR_QUIET_RADIUS: rad_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         cx_ff        <= CFG_W'(480);
         cy_ff        <= CFG_W'(480);
         rad_ff       <= CFG_W'(420);
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rad_ff       <= rad_in;
      end
      work_ff <= work_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/nbgs_ram.sv
// ----------------------------------------------------------------------------
// nbgs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module nbgs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nbgs_div.sv
// ----------------------------------------------------------------------------
// nbgs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module nbgs_div
   import nbgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(shifted - {1'b0, den_ff}) : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/nbgs_isqrt.sv
// ----------------------------------------------------------------------------
// nbgs_isqrt: iterative integer square root
// Digit-by-digit method, one result bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module nbgs_isqrt
   import nbgs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] res_ff, res_in;
   logic [DIV_W-1:0] bit_ff, bit_in;
   logic [DIV_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = radicand;
         res_in  = '0;
         bit_in  = DIV_W'(1) << (DIV_W - 2);
      end else if (busy_ff) begin
         if (num_ff >= trial) begin
            num_in = num_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule
